// ===== hdl/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants for the k-nearest inverse-distance interpolator.
// ----------------------------------------------------------------------------
package knn_pkg;
  localparam int CoordW   = 24;
  localparam int D2W      = 51;
  localparam int WFracW   = 16;
  localparam int WW       = WFracW + 1;
  localparam int ProdW    = CoordW + WW;
  localparam int AccW     = ProdW + 5;
  localparam int WsumW    = WW + 5;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HIT     = 3'd1;
  localparam logic [2:0] ST_FEW     = 3'd2;
  localparam logic [2:0] ST_LOADED  = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [CoordW-1:0] field_in_x;
    logic [CoordW-1:0] field_in_y;
    logic [CoordW-1:0] field_in_z;
  } in_word_t;

  typedef struct packed {
    logic [CoordW-1:0] field_out_x;
    logic [CoordW-1:0] field_out_y;
    logic [CoordW-1:0] field_out_z;
    logic [2:0]        status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input word
    logic scan_start;  // reset scan index, clear best list
    logic scan_rd;     // issue read of entry at scan index
    logic scan_eval;   // evaluate registered read data
    logic write_pt;    // append point
    logic clear_tbl;
    logic wt_start;    // start weight divisions
    logic wt_step;
    logic div_start;   // start final divisions
    logic div_step;
    logic res_load;
  } knn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan_done;
    logic       hit;
    logic       dup;
    logic       full;
    logic       few;
    logic       wt_done;
    logic       div_done;
  } knn_stat_t;
endpackage

// ===== hdl/knn_if.sv =====
// ----------------------------------------------------------------------------
// knn_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface knn_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/knn_ram.sv =====
// ----------------------------------------------------------------------------
// knn_ram
// Single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module knn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/knn_datapath.sv =====
// ----------------------------------------------------------------------------
// knn_datapath
// Point table, distance scan with sorted K-best list, weight and result dividers.
// ----------------------------------------------------------------------------
module knn_datapath import knn_pkg::*; #(
  parameter int NearestK   = 8,
  parameter int TableDepth = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  knn_cmd_t  cmd,
  output knn_stat_t stat,
  input  in_word_t  in_word,
  output out_word_t out_word
);
  localparam int AW = $clog2(TableDepth);
  localparam int CW = $clog2(TableDepth + 1);
  localparam int KW = $clog2(NearestK + 1);
  localparam int KI = (NearestK > 1) ? $clog2(NearestK) : 1;
  localparam int RowW = 6 * CoordW;

  in_word_t          req;
  logic [CW-1:0]     point_count;
  logic [CW-1:0]     scan_idx;
  logic [CW-1:0]     eval_idx;
  logic [RowW-1:0]   rd_row;
  logic [AW-1:0]     raddr;

  logic [D2W-1:0]    best_d [NearestK];
  logic [AW-1:0]     best_i [NearestK];
  logic [KW-1:0]     n_best;
  logic              hit;
  logic [AW-1:0]     hit_idx;
  logic              dup;

  // distance pipeline stage
  logic signed [CoordW:0]     dx, dy, dz;
  logic signed [2*CoordW+1:0] dx2, dy2, dz2;
  logic [2*CoordW+1:0]        sx, sy, sz;
  logic [D2W-1:0]             d2;
  logic                       match;

  assign raddr = scan_idx[AW-1:0];

  knn_ram #(.Width(RowW), .Depth(TableDepth)) u_tbl (
    .clk   (clk),
    .we    (cmd.write_pt),
    .waddr (point_count[AW-1:0]),
    .wdata ({req.pos_x, req.pos_y, req.pos_z,
             req.field_in_x, req.field_in_y, req.field_in_z}),
    .raddr (raddr),
    .rdata (rd_row)
  );

  always_comb begin
    dx = $signed({rd_row[6*CoordW-1], rd_row[6*CoordW-1 -: CoordW]})
       - $signed({req.pos_x[CoordW-1], req.pos_x});
    dy = $signed({rd_row[5*CoordW-1], rd_row[5*CoordW-1 -: CoordW]})
       - $signed({req.pos_y[CoordW-1], req.pos_y});
    dz = $signed({rd_row[4*CoordW-1], rd_row[4*CoordW-1 -: CoordW]})
       - $signed({req.pos_z[CoordW-1], req.pos_z});
    dx2 = dx * dx;
    dy2 = dy * dy;
    dz2 = dz * dz;
    match = (rd_row[RowW-1 -: 3*CoordW] == {req.pos_x, req.pos_y, req.pos_z});
  end

  // register squares before the sum
  logic                     eval_p;
  logic                     eval_q;
  logic                     match_q;
  logic [CW-1:0]            idx_q;
  always_ff @(posedge clk) begin
    sx <= unsigned'(dx2);
    sy <= unsigned'(dy2);
    sz <= unsigned'(dz2);
    match_q <= match;
    idx_q   <= eval_idx;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_p <= 1'b0;
      eval_q <= 1'b0;
    end else begin
      eval_p <= cmd.scan_eval;
      eval_q <= eval_p;
    end
  end
  assign d2 = D2W'(sx) + D2W'(sy) + D2W'(sz);

  // insertion into sorted list: strictly-greater entries shift down
  logic [KW-1:0] ins_pos;
  logic          do_ins;
  always_comb begin
    ins_pos = n_best;
    for (int k = NearestK - 1; k >= 0; k--) begin
      if (k < n_best && best_d[k] > d2) ins_pos = KW'(k);
    end
    do_ins = (n_best < KW'(NearestK)) || (ins_pos < KW'(NearestK));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cmd.clear_tbl) begin
      point_count <= '0;
    end else if (cmd.write_pt) begin
      point_count <= point_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req <= in_word;
    if (cmd.scan_start) begin
      scan_idx <= '0;
      eval_idx <= '0;
      n_best   <= '0;
      hit      <= 1'b0;
      dup      <= 1'b0;
    end else begin
      if (cmd.scan_rd) scan_idx <= scan_idx + 1'b1;
      if (cmd.scan_eval) eval_idx <= scan_idx;
      if (eval_q && !hit && !dup) begin
        if (match_q) begin
          hit     <= 1'b1;
          dup     <= 1'b1;
          hit_idx <= idx_q[AW-1:0];
        end else if (do_ins) begin
          for (int k = NearestK - 1; k > 0; k--) begin
            if (KW'(k) > ins_pos) begin
              best_d[k] <= best_d[k-1];
              best_i[k] <= best_i[k-1];
            end
          end
          best_d[ins_pos[KI-1:0]] <= d2;
          best_i[ins_pos[KI-1:0]] <= idx_q[AW-1:0];
          if (n_best < KW'(NearestK)) n_best <= n_best + 1'b1;
        end
      end
    end
  end

  assign stat.scan_done = (scan_idx >= point_count);
  assign stat.hit  = hit;
  assign stat.dup  = dup;
  assign stat.full = (point_count >= CW'(TableDepth));
  assign stat.few  = (point_count < CW'(NearestK));

  // Weight phase: for k, read field row of best_i[k], divide d2min/d2k
  // (restoring, one bit a step), multiply by fields, accumulate.
  logic [KW-1:0]       wk;
  logic [4:0]          wbit;
  logic [D2W:0]        wrem;
  logic [WW-1:0]       wq;
  logic [1:0]          wph;   // 0 div,1 read wait,2 mult,3 acc
  logic signed [ProdW-1:0] px, py, pz;
  logic signed [AccW-1:0]  acc_x, acc_y, acc_z;
  logic [WsumW-1:0]    wsum;
  logic                wt_done;
  logic [AW-1:0]       fld_addr;
  logic [RowW-1:0]     fld_row;

  knn_ram #(.Width(RowW), .Depth(TableDepth)) u_fld (
    .clk   (clk),
    .we    (cmd.write_pt),
    .waddr (point_count[AW-1:0]),
    .wdata ({req.pos_x, req.pos_y, req.pos_z,
             req.field_in_x, req.field_in_y, req.field_in_z}),
    .raddr (fld_addr),
    .rdata (fld_row)
  );

  assign fld_addr = hit ? hit_idx : best_i[wk[KI-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wt_done <= 1'b0;
    end else if (cmd.wt_start) begin
      wk <= '0; wbit <= '0; wrem <= {1'b0, best_d[0]}; wq <= '0; wph <= 2'd0;
      acc_x <= '0; acc_y <= '0; acc_z <= '0; wsum <= '0;
      wt_done <= 1'b0;
    end else if (cmd.wt_step && !wt_done) begin
      case (wph)
        2'd0: begin
          if (wrem >= {1'b0, best_d[wk[KI-1:0]]}) begin
            wq   <= {wq[WW-2:0], 1'b1};
            wrem <= (wrem - {1'b0, best_d[wk[KI-1:0]]}) << 1;
          end else begin
            wq   <= {wq[WW-2:0], 1'b0};
            wrem <= wrem << 1;
          end
          if (wbit == 5'(WFracW)) wph <= 2'd1;
          wbit <= wbit + 1'b1;
        end
        2'd1: wph <= 2'd2;
        2'd2: begin
          px <= $signed({1'b0, wq}) * $signed(fld_row[3*CoordW-1 -: CoordW]);
          py <= $signed({1'b0, wq}) * $signed(fld_row[2*CoordW-1 -: CoordW]);
          pz <= $signed({1'b0, wq}) * $signed(fld_row[CoordW-1 -: CoordW]);
          wph <= 2'd3;
        end
        default: begin
          acc_x <= acc_x + AccW'(px);
          acc_y <= acc_y + AccW'(py);
          acc_z <= acc_z + AccW'(pz);
          wsum  <= wsum + WsumW'(wq);
          wbit  <= '0; wq <= '0; wrem <= {1'b0, best_d[0]}; wph <= 2'd0;
          if (wk == KW'(NearestK - 1)) wt_done <= 1'b1;
          wk <= wk + 1'b1;
        end
      endcase
    end
  end
  assign stat.wt_done = wt_done;

  // Final division: three signed quotients, magnitude restoring, shared steps.
  logic [AccW-1:0]  mag [3];
  logic [3-1:0]     neg;
  logic [AccW-1:0]  rem [3];
  logic [AccW-1:0]  quo [3];
  logic [6:0]       dbit;
  logic             div_done;
  logic [AccW-1:0]  dvs;
  assign dvs = AccW'(wsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_done <= 1'b0;
    end else if (cmd.div_start) begin
      mag[0] <= acc_x[AccW-1] ? AccW'(-acc_x) : AccW'(acc_x);
      mag[1] <= acc_y[AccW-1] ? AccW'(-acc_y) : AccW'(acc_y);
      mag[2] <= acc_z[AccW-1] ? AccW'(-acc_z) : AccW'(acc_z);
      neg    <= {acc_z[AccW-1], acc_y[AccW-1], acc_x[AccW-1]};
      for (int c = 0; c < 3; c++) begin
        rem[c] <= '0; quo[c] <= '0;
      end
      dbit <= '0;
      div_done <= 1'b0;
    end else if (cmd.div_step && !div_done) begin
      for (int c = 0; c < 3; c++) begin
        logic [AccW:0] t;
        t = {rem[c], mag[c][AccW-1]};
        if (t >= {1'b0, dvs}) begin
          rem[c] <= AccW'(t - {1'b0, dvs});
          quo[c] <= {quo[c][AccW-2:0], 1'b1};
        end else begin
          rem[c] <= AccW'(t);
          quo[c] <= {quo[c][AccW-2:0], 1'b0};
        end
        mag[c] <= mag[c] << 1;
      end
      if (dbit == 7'(AccW - 1)) div_done <= 1'b1;
      dbit <= dbit + 1'b1;
    end
  end
  assign stat.div_done = div_done;

  logic [CoordW-1:0] qx, qy, qz;
  assign qx = neg[0] ? CoordW'(-quo[0]) : quo[0][CoordW-1:0];
  assign qy = neg[1] ? CoordW'(-quo[1]) : quo[1][CoordW-1:0];
  assign qz = neg[2] ? CoordW'(-quo[2]) : quo[2][CoordW-1:0];

  // exact hit takes the stored field row at hit_idx
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_word.field_out_x <= hit ? fld_row[3*CoordW-1 -: CoordW] : qx;
      out_word.field_out_y <= hit ? fld_row[2*CoordW-1 -: CoordW] : qy;
      out_word.field_out_z <= hit ? fld_row[CoordW-1 -: CoordW] : qz;
      out_word.status      <= ST_OK;
    end
  end
endmodule

// ===== hdl/knn_ctrl.sv =====
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer for load, query and clear words; owns the result valid and status.
// ----------------------------------------------------------------------------
module knn_ctrl import knn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] in_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [2:0] status,
  output logic      zero_f,
  output knn_cmd_t  cmd,
  input  knn_stat_t stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_WT   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_HITR = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] op;
  logic [1:0] drain;
  logic [1:0] hitw;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit && op == CMD_QUERY) state_next = S_HITR;
        else if (stat.dup) state_next = S_DEC;
        else if (stat.scan_done) state_next = S_DRAIN;
        else begin
          cmd.scan_rd = 1'b1;
          cmd.scan_eval = 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain == 2'd3) begin
          if (stat.hit && op == CMD_QUERY) state_next = S_HITR;
          else state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (op == CMD_LOAD && !stat.dup && !stat.full) cmd.write_pt = 1'b1;
        if (op == CMD_CLEAR) cmd.clear_tbl = 1'b1;
        if (op == CMD_QUERY && !stat.few) begin
          cmd.wt_start = 1'b1;
          state_next = S_WT;
        end else state_next = S_OUT;
      end
      S_WT: begin
        cmd.wt_step = 1'b1;
        if (stat.wt_done) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.res_load = 1'b1;
          state_next = S_OUT;
        end
      end
      S_HITR: begin
        if (hitw == 2'd2) begin
          cmd.res_load = 1'b1;
          state_next = S_OUT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; op <= CMD_LOAD;
      drain <= '0; hitw <= '0; status <= ST_OK; zero_f <= 1'b1;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && in_ready) begin
        op <= in_cmd; drain <= '0; hitw <= '0;
      end
      if (state == S_DRAIN) drain <= drain + 1'b1;
      if (state == S_HITR) hitw <= hitw + 1'b1;
      if (state == S_DEC) begin
        zero_f <= 1'b1;
        case (op)
          CMD_LOAD:  status <= stat.dup ? ST_DUP : (stat.full ? ST_FULL : ST_LOADED);
          CMD_CLEAR: status <= ST_CLEARED;
          CMD_QUERY: begin
            status <= stat.few ? ST_FEW : ST_OK;
            zero_f <= stat.few;
          end
          default:   status <= ST_OK;
        endcase
      end
      if (state == S_HITR && hitw == 2'd2) begin
        status <= stat.few ? ST_FEW : ST_HIT;
        zero_f <= stat.few;
      end
      if (state == S_OUT) out_valid <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    cmd.write_pt |-> op == CMD_LOAD) else $error("write outside load");
  assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> out_valid) else $error("result not posted");
endmodule

// ===== hdl/knn_inverse_distance_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// knn_inverse_distance_interpolator_core
// K-nearest inverse-square-distance interpolator over a table of 3-D points.
//
//   channel  dir  word
//   in       sink   cmd, pos_x/y/z, field_in_x/y/z
//   out      source field_out_x/y/z, status
//
// A word runs alone: the table scan reads one point a cycle, a query then
// runs a weight division per neighbor (divide, read, multiply, accumulate)
// and then the final divides. A stalled result holds the block.
// rst is synchronous; it empties the table.
// ----------------------------------------------------------------------------
module knn_inverse_distance_interpolator_core import knn_pkg::*; #(
  parameter int NearestK   = 8,
  parameter int TableDepth = 1024
) (
  input logic clk,
  input logic rst,
  knn_if.sink   in_ch,
  knn_if.source out_ch
);
  knn_cmd_t  cmd;
  knn_stat_t stat;
  out_word_t dp_out;
  logic [2:0] status;
  logic       zero_f;

  knn_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .zero_f(zero_f),
    .cmd(cmd), .stat(stat)
  );

  knn_datapath #(.NearestK(NearestK), .TableDepth(TableDepth)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_word(in_ch.data), .out_word(dp_out)
  );

  always_comb begin
    out_ch.data.status = status;
    if (zero_f) begin
      out_ch.data.field_out_x = '0;
      out_ch.data.field_out_y = '0;
      out_ch.data.field_out_z = '0;
    end else begin
      out_ch.data.field_out_x = dp_out.field_out_x;
      out_ch.data.field_out_y = dp_out.field_out_y;
      out_ch.data.field_out_z = dp_out.field_out_z;
    end
  end
endmodule
